>>> src/tpdd_pkg.sv
// tpdd_pkg: shared types and constants of the tilt packet to differential drive block
// no dependencies; used by every module of the block
`default_nettype none

package tpdd_pkg;

    localparam int MAG_W  = 17;   // tilt magnitude, 16 fraction bits
    localparam int DUTY_W = 16;   // wheel duty value
    localparam int RAW_W  = 15;   // floor(mag * 10000 / 65536) fits in 15 bits
    localparam int CFG_W  = 17;   // widest configuration register
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] START_BYTE = 8'h21;  // '!'
    localparam logic [7:0] TYPE_QUAT  = 8'h51;  // 'Q'

    // configuration reset values
    localparam logic [MAG_W-1:0]  TILT_LOW_RST    = 17'd6554;
    localparam logic [MAG_W-1:0]  TILT_HIGH_RST   = 17'd42598;
    localparam logic [DUTY_W-1:0] PWM_FLOOR_RST   = 16'd2500;
    localparam logic [DUTY_W-1:0] PWM_CEILING_RST = 16'd14000;
    localparam logic [DUTY_W-1:0] DUTY_CRUISE_RST = 16'd4500;
    localparam logic [DUTY_W-1:0] DUTY_TRAIL_RST  = 16'd3000;
    localparam logic [DUTY_W-1:0] PWM_TURN_RST    = 16'd2300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILT_LOW    = 3'd0,
        CFG_TILT_HIGH   = 3'd1,
        CFG_PWM_FLOOR   = 3'd2,
        CFG_PWM_CEILING = 3'd3,
        CFG_PROP_MODE   = 3'd4,
        CFG_DUTY_CRUISE = 3'd5,
        CFG_DUTY_TRAIL  = 3'd6,
        CFG_PWM_TURN    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIR_STOP      = 3'd0,
        DIR_FORWARD   = 3'd1,
        DIR_BACKWARD  = 3'd2,
        DIR_ROT_RIGHT = 3'd3,
        DIR_ROT_LEFT  = 3'd4
    } t_dir;

    typedef enum logic [2:0] {
        LED_WHITE    = 3'd0,
        LED_SKY_BLUE = 3'd1,
        LED_GREEN    = 3'd2,
        LED_BLUE     = 3'd3,
        LED_PINK     = 3'd4,
        LED_YELLOW   = 3'd5,
        LED_RED      = 3'd6
    } t_led;

    // duty settings seen by the drive stage
    typedef struct packed {
        logic [DUTY_W-1:0] pwm_floor;
        logic [DUTY_W-1:0] pwm_ceiling;
        logic              prop_mode;
        logic [DUTY_W-1:0] duty_cruise;
        logic [DUTY_W-1:0] duty_trail;
        logic [DUTY_W-1:0] pwm_turn;
    } t_duty_cfg;

    // completed packet as held by the assembler
    typedef struct packed {
        logic        bad;
        logic [31:0] pitch_raw;
        logic [31:0] roll_raw;
    } t_pkt;

    // decoded tilt, between decode and drive stages
    typedef struct packed {
        logic             bad;
        logic             x_pos;
        logic             x_neg;
        logic             y_pos;
        logic             y_neg;
        logic [RAW_W-1:0] dx_raw;
        logic [RAW_W-1:0] dy_raw;
    } t_dec;

endpackage

`default_nettype wire

>>> src/tpdd_assembler.sv
// tpdd_assembler: start byte hunt, byte counter and packet field registers
// depends on tpdd_pkg
`default_nettype none

module tpdd_assembler #(
    parameter int PACKET_BYTES = 19
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_take,
    output logic                   o_pkt_valid,
    output tpdd_pkg::t_pkt         o_pkt
);

    localparam int CNT_W = $clog2(PACKET_BYTES);
    localparam logic [CNT_W-1:0] POS_TYPE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] POS_PITCH0 = CNT_W'(2);
    localparam logic [CNT_W-1:0] POS_PITCH3 = CNT_W'(5);
    localparam logic [CNT_W-1:0] POS_ROLL0  = CNT_W'(6);
    localparam logic [CNT_W-1:0] POS_ROLL3  = CNT_W'(9);
    localparam logic [CNT_W-1:0] POS_LAST   = CNT_W'(PACKET_BYTES - 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_type,  n_type;
    logic [31:0]      r_pitch, n_pitch;
    logic [31:0]      r_roll,  n_roll;
    logic             r_pkt_valid, n_pkt_valid;
    logic             accept;
    logic [1:0]       lane;

    assign o_ready = !r_pkt_valid || i_take;
    assign accept  = i_valid && o_ready;
    // byte lane within a float: position minus two, modulo four
    assign lane    = 2'(r_count - POS_PITCH0);

    always_comb begin
        n_count     = r_count;
        n_type      = r_type;
        n_pitch     = r_pitch;
        n_roll      = r_roll;
        n_pkt_valid = r_pkt_valid && !i_take;
        if (accept) begin
            if (r_count == '0) begin
                if (i_byte == tpdd_pkg::START_BYTE) begin
                    n_count = POS_TYPE;
                end
            end else begin
                if (r_count == POS_TYPE) begin
                    n_type = i_byte;
                end else if (r_count >= POS_PITCH0 && r_count <= POS_PITCH3) begin
                    n_pitch[{lane, 3'b000} +: 8] = i_byte;
                end else if (r_count >= POS_ROLL0 && r_count <= POS_ROLL3) begin
                    n_roll[{lane, 3'b000} +: 8] = i_byte;
                end
                if (r_count == POS_LAST) begin
                    n_count     = '0;
                    n_pkt_valid = 1'b1;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_type      <= '0;
            r_pitch     <= '0;
            r_roll      <= '0;
            r_pkt_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_type      <= n_type;
            r_pitch     <= n_pitch;
            r_roll      <= n_roll;
            r_pkt_valid <= n_pkt_valid;
        end
    end

    assign o_pkt_valid   = r_pkt_valid;
    assign o_pkt.bad       = (r_type != tpdd_pkg::TYPE_QUAT);
    assign o_pkt.pitch_raw = r_pitch;
    assign o_pkt.roll_raw  = r_roll;

endmodule

`default_nettype wire

>>> src/tpdd_decode.sv
// tpdd_decode: float to fixed magnitude, tilt window test and duty scaling, registered
// depends on tpdd_pkg
`default_nettype none

module tpdd_decode (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_adv,
    input  wire logic                          i_valid,
    input  wire tpdd_pkg::t_pkt                i_pkt,
    input  wire logic [tpdd_pkg::MAG_W-1:0]    i_tilt_low,
    input  wire logic [tpdd_pkg::MAG_W-1:0]    i_tilt_high,
    output logic                               o_valid,
    output tpdd_pkg::t_dec                     o_dec
);

    localparam logic [7:0] EXP_SAT = 8'd134;  // 128.0 and above saturate
    localparam logic [7:0] EXP_MIN = 8'd103;  // below this the value shifts out
    localparam logic [tpdd_pkg::MAG_W-1:0] MAG_MAX = '1;
    localparam logic [13:0] DUTY_SCALE = 14'd10000;
    localparam int PROD_W = tpdd_pkg::MAG_W + 14;

    function automatic logic [tpdd_pkg::MAG_W-1:0] to_mag(input logic [31:0] bits);
        logic [7:0]  e;
        logic [23:0] mant;
        logic [4:0]  rsh;
        logic [23:0] sh;
        logic [tpdd_pkg::MAG_W-1:0] res;
        e    = bits[30:23];
        mant = {1'b1, bits[22:0]};
        rsh  = 5'(EXP_SAT - e);
        sh   = mant >> rsh;
        if (e == '0) begin
            res = '0;
        end else if (e >= EXP_SAT) begin
            res = MAG_MAX;
        end else if (e < EXP_MIN) begin
            res = '0;
        end else if (sh > 24'(MAG_MAX)) begin
            res = MAG_MAX;
        end else begin
            res = sh[tpdd_pkg::MAG_W-1:0];
        end
        return res;
    endfunction

    logic [tpdd_pkg::MAG_W-1:0] mx, my;
    logic [PROD_W-1:0]          px, py;
    logic                       x_in, y_in, x_sign, y_sign;
    tpdd_pkg::t_dec             n_dec, r_dec;
    logic                       r_valid;

    always_comb begin
        mx     = to_mag(i_pkt.pitch_raw);
        my     = to_mag(i_pkt.roll_raw);
        x_sign = i_pkt.pitch_raw[31];
        y_sign = i_pkt.roll_raw[31];
        x_in   = (mx > i_tilt_low) && (mx < i_tilt_high);
        y_in   = (my > i_tilt_low) && (my < i_tilt_high);
        px     = PROD_W'(mx) * PROD_W'(DUTY_SCALE);
        py     = PROD_W'(my) * PROD_W'(DUTY_SCALE);
        n_dec.bad    = i_pkt.bad;
        n_dec.x_pos  = x_in && !x_sign;
        n_dec.x_neg  = x_in && x_sign;
        n_dec.y_pos  = y_in && !y_sign;
        n_dec.y_neg  = y_in && y_sign;
        n_dec.dx_raw = px[16 +: tpdd_pkg::RAW_W];
        n_dec.dy_raw = py[16 +: tpdd_pkg::RAW_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

`default_nettype wire

>>> src/tpdd_drive.sv
// tpdd_drive: duty clamping, drive case selection and result register
// depends on tpdd_pkg
`default_nettype none

module tpdd_drive (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire tpdd_pkg::t_dec                 i_dec,
    input  wire tpdd_pkg::t_duty_cfg            i_cfg,
    output logic                                o_take,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [2:0]                          o_drive_dir,
    output logic [tpdd_pkg::DUTY_W-1:0]         o_left_duty,
    output logic [tpdd_pkg::DUTY_W-1:0]         o_right_duty,
    output logic [2:0]                          o_led_colour,
    output logic                                o_bad_packet
);

    localparam int SUM_W = tpdd_pkg::DUTY_W + 1;

    // raise to floor, then lower to ceiling
    function automatic logic [tpdd_pkg::DUTY_W-1:0] clamp_duty(
        input logic [SUM_W-1:0]           v,
        input logic [tpdd_pkg::DUTY_W-1:0] lo,
        input logic [tpdd_pkg::DUTY_W-1:0] hi
    );
        logic [SUM_W-1:0] t;
        t = (v < SUM_W'(lo)) ? SUM_W'(lo) : v;
        t = (t > SUM_W'(hi)) ? SUM_W'(hi) : t;
        return t[tpdd_pkg::DUTY_W-1:0];
    endfunction

    logic [tpdd_pkg::DUTY_W-1:0] dxc, dyc, sumc;
    logic                        x_in, y_in;
    tpdd_pkg::t_dir              n_dir, r_dir;
    tpdd_pkg::t_led              n_led, r_led;
    logic [tpdd_pkg::DUTY_W-1:0] n_left, r_left, n_right, r_right;
    logic                        n_bad, r_bad;
    logic                        r_valid;

    assign o_take = !r_valid || i_ready;

    always_comb begin
        dxc  = clamp_duty(SUM_W'(i_dec.dx_raw), i_cfg.pwm_floor, i_cfg.pwm_ceiling);
        dyc  = clamp_duty(SUM_W'(i_dec.dy_raw), i_cfg.pwm_floor, i_cfg.pwm_ceiling);
        sumc = clamp_duty(SUM_W'(dxc) + SUM_W'(dyc), i_cfg.pwm_floor, i_cfg.pwm_ceiling);
        x_in = i_dec.x_pos || i_dec.x_neg;
        y_in = i_dec.y_pos || i_dec.y_neg;
        n_bad   = 1'b0;
        n_dir   = tpdd_pkg::DIR_STOP;
        n_led   = tpdd_pkg::LED_RED;
        n_left  = '0;
        n_right = '0;
        priority if (i_dec.bad) begin
            n_bad = 1'b1;
            n_led = tpdd_pkg::LED_WHITE;
        end else if (x_in && y_in) begin
            n_dir = i_dec.x_pos ? tpdd_pkg::DIR_FORWARD : tpdd_pkg::DIR_BACKWARD;
            n_led = i_dec.x_pos ? tpdd_pkg::LED_WHITE : tpdd_pkg::LED_SKY_BLUE;
            if (i_dec.y_pos) begin
                n_left  = i_cfg.prop_mode ? sumc : i_cfg.duty_cruise;
                n_right = i_cfg.prop_mode ? dxc  : i_cfg.duty_trail;
            end else begin
                n_left  = i_cfg.prop_mode ? dxc  : i_cfg.duty_trail;
                n_right = i_cfg.prop_mode ? sumc : i_cfg.duty_cruise;
            end
        end else if (x_in) begin
            n_dir   = i_dec.x_pos ? tpdd_pkg::DIR_FORWARD : tpdd_pkg::DIR_BACKWARD;
            n_led   = i_dec.x_pos ? tpdd_pkg::LED_GREEN : tpdd_pkg::LED_BLUE;
            n_left  = i_cfg.prop_mode ? dxc : i_cfg.duty_cruise;
            n_right = n_left;
        end else if (y_in) begin
            n_dir   = i_dec.y_pos ? tpdd_pkg::DIR_ROT_RIGHT : tpdd_pkg::DIR_ROT_LEFT;
            n_led   = i_dec.y_pos ? tpdd_pkg::LED_PINK : tpdd_pkg::LED_YELLOW;
            n_left  = i_cfg.prop_mode ? dyc : i_cfg.pwm_turn;
            n_right = n_left;
        end else begin
            n_dir = tpdd_pkg::DIR_STOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_dir   <= n_dir;
            r_led   <= n_led;
            r_left  <= n_left;
            r_right <= n_right;
            r_bad   <= n_bad;
        end
    end

    assign o_valid      = r_valid;
    assign o_drive_dir  = r_dir;
    assign o_left_duty  = r_left;
    assign o_right_duty = r_right;
    assign o_led_colour = r_led;
    assign o_bad_packet = r_bad;

endmodule

`default_nettype wire

>>> src/tilt_packet_to_differential_drive.sv
// tilt_packet_to_differential_drive: top level, configuration registers and stage wiring
// depends on tpdd_pkg, tpdd_assembler, tpdd_decode, tpdd_drive
`default_nettype none

// Takes one received serial byte per item and turns tilt packets into wheel commands.
// Bytes are dropped until a '!' start byte; that byte and the next PACKET_BYTES-1 bytes
// form one packet. Byte 1 is the type, bytes 2..5 and 6..9 are the x and y tilt as
// little-endian IEEE singles; everything after that is ignored. The last byte of a
// packet yields exactly one result item: a stop with o_bad_packet set when the type is
// not 'Q', otherwise a drive direction, two wheel duties and an LED colour. The block
// accepts one byte every cycle while o_rx_ready is high. After the last byte, the
// packet sits in the assembler registers, then in the decode register (float to
// fixed and the 10000 scaling multiply), then in the result register (duty clamping
// and drive case choice), which drives the outputs. A waiting result blocks nothing
// until all three stages are full; only then is o_rx_ready dropped. Configuration is
// a plain write port, to be used only while no packet is in flight.

module tilt_packet_to_differential_drive #(
    parameter int PACKET_BYTES = 19
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // received byte channel
    input  wire logic                              i_rx_valid,
    output logic                                   o_rx_ready,
    input  wire logic [7:0]                        i_rx_byte,
    // drive command channel
    output logic                                   o_drv_valid,
    input  wire logic                              i_drv_ready,
    output logic [2:0]                             o_drive_dir,
    output logic [tpdd_pkg::DUTY_W-1:0]            o_left_duty,
    output logic [tpdd_pkg::DUTY_W-1:0]            o_right_duty,
    output logic [2:0]                             o_led_colour,
    output logic                                   o_bad_packet,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [tpdd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tpdd_pkg::CFG_W-1:0]        i_cfg_data
);

    // configuration registers
    logic [tpdd_pkg::MAG_W-1:0]  r_tilt_low, r_tilt_high;
    tpdd_pkg::t_duty_cfg         r_duty_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_low             <= tpdd_pkg::TILT_LOW_RST;
            r_tilt_high            <= tpdd_pkg::TILT_HIGH_RST;
            r_duty_cfg.pwm_floor   <= tpdd_pkg::PWM_FLOOR_RST;
            r_duty_cfg.pwm_ceiling <= tpdd_pkg::PWM_CEILING_RST;
            r_duty_cfg.prop_mode   <= 1'b1;
            r_duty_cfg.duty_cruise <= tpdd_pkg::DUTY_CRUISE_RST;
            r_duty_cfg.duty_trail  <= tpdd_pkg::DUTY_TRAIL_RST;
            r_duty_cfg.pwm_turn    <= tpdd_pkg::PWM_TURN_RST;
        end else if (i_cfg_we) begin
            unique case (tpdd_pkg::t_cfg_idx'(i_cfg_index))
                tpdd_pkg::CFG_TILT_LOW:    r_tilt_low  <= i_cfg_data;
                tpdd_pkg::CFG_TILT_HIGH:   r_tilt_high <= i_cfg_data;
                tpdd_pkg::CFG_PWM_FLOOR:   r_duty_cfg.pwm_floor   <= i_cfg_data[15:0];
                tpdd_pkg::CFG_PWM_CEILING: r_duty_cfg.pwm_ceiling <= i_cfg_data[15:0];
                tpdd_pkg::CFG_PROP_MODE:   r_duty_cfg.prop_mode   <= i_cfg_data[0];
                tpdd_pkg::CFG_DUTY_CRUISE: r_duty_cfg.duty_cruise <= i_cfg_data[15:0];
                tpdd_pkg::CFG_DUTY_TRAIL:  r_duty_cfg.duty_trail  <= i_cfg_data[15:0];
                tpdd_pkg::CFG_PWM_TURN:    r_duty_cfg.pwm_turn    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // stage wiring: each stage moves when the next one can take its item
    logic           pkt_valid, dec_valid, dec_adv, drv_take;
    tpdd_pkg::t_pkt pkt;
    tpdd_pkg::t_dec dec;

    assign dec_adv = !dec_valid || drv_take;

    tpdd_assembler #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_assembler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_rx_valid),
        .o_ready     (o_rx_ready),
        .i_byte      (i_rx_byte),
        .i_take      (dec_adv),
        .o_pkt_valid (pkt_valid),
        .o_pkt       (pkt)
    );

    tpdd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (dec_adv),
        .i_valid     (pkt_valid),
        .i_pkt       (pkt),
        .i_tilt_low  (r_tilt_low),
        .i_tilt_high (r_tilt_high),
        .o_valid     (dec_valid),
        .o_dec       (dec)
    );

    tpdd_drive u_drive (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (dec_valid),
        .i_dec        (dec),
        .i_cfg        (r_duty_cfg),
        .o_take       (drv_take),
        .o_valid      (o_drv_valid),
        .i_ready      (i_drv_ready),
        .o_drive_dir  (o_drive_dir),
        .o_left_duty  (o_left_duty),
        .o_right_duty (o_right_duty),
        .o_led_colour (o_led_colour),
        .o_bad_packet (o_bad_packet)
    );

    // a bad packet always reports a stop with both wheels off
    a_bad_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_drv_valid && o_bad_packet) |->
            (o_drive_dir == tpdd_pkg::DIR_STOP && o_left_duty == '0 && o_right_duty == '0))
        else $error("bad packet result is not a stop");

    // a stop command never carries a duty
    a_stop_no_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_drv_valid && o_drive_dir == tpdd_pkg::DIR_STOP) |->
            (o_left_duty == '0 && o_right_duty == '0))
        else $error("stop with nonzero duty");

    // the byte side stalls only behind a result that is being held off
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rx_ready |-> (o_drv_valid && !i_drv_ready && dec_valid && pkt_valid))
        else $error("byte channel stalled without a full pipeline");

    // a result enters the output register only from a decoded item
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_drv_valid)) |-> $past(dec_valid))
        else $error("result appeared without a decoded item");

endmodule

`default_nettype wire
